[hdl/mrlos_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrlos_pkg
// Shared types and constants of the least-outstanding mirror read selector.
// ---------------------------------------------------------------------------
package mrlos_pkg;

    // Parameter defaults
    localparam int MAX_MIRRORS_DEF  = 8;
    localparam int COUNTER_BITS_DEF = 48;

    // Fixed field widths
    localparam int MIRROR_COUNT_W = 4;
    localparam int PRESENT_MASK_W = 8;
    localparam int CFG_DATA_W     = 8;
    localparam int CFG_INDEX_W    = 1;
    localparam int MIRROR_IDX_W   = 3;
    localparam int BLOCK_COUNT_W  = 32;
    localparam int AFTER_W        = 48;

    // Reset values of the configuration registers
    localparam logic [MIRROR_COUNT_W-1:0] MIRROR_COUNT_RST = 4'd2;
    localparam logic [PRESENT_MASK_W-1:0] PRESENT_MASK_RST = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENT_MASK = 1'b1;

    // Command codes
    localparam logic CMD_PICK    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input item, clear the search
        logic scan;     // examine one counter
        logic commit;   // update counter, load result register
    } mrlos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_pick;   // offered item is a pick
        logic scan_last; // scan is on the last counter
        logic out_free;  // result register can take a new result
    } mrlos_status_t;

endpackage

[hdl/mrlos_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrlos_ctrl
// Sequencer: accept an item, scan the counters for a pick, then commit.
// ---------------------------------------------------------------------------
module mrlos_ctrl
    import mrlos_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mrlos_status_t status,
    output mrlos_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_pick ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/mrlos_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrlos_dp
// Counters, configuration, min search and read-modify-write, result register.
// ---------------------------------------------------------------------------
module mrlos_dp
    import mrlos_pkg::*;
#(
    parameter int MAX_MIRRORS  = MAX_MIRRORS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_cmd,
    input  logic [MIRROR_IDX_W-1:0]  s_mirror_index,
    input  logic [BLOCK_COUNT_W-1:0] s_block_count,
    input  mrlos_cmd_t               cmd,
    output mrlos_status_t            status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [MIRROR_IDX_W-1:0]  m_chosen_mirror,
    output logic                     m_none_available,
    output logic                     m_count_error,
    output logic [AFTER_W-1:0]       m_outstanding_after
);

    localparam int IW = (MAX_MIRRORS > 1) ? $clog2(MAX_MIRRORS) : 1;
    localparam int XW = ((IW > MIRROR_IDX_W) ? IW : MIRROR_IDX_W) + 1;
    localparam int CW = ((IW > MIRROR_COUNT_W) ? IW : MIRROR_COUNT_W) + 1;
    localparam int CB = COUNTER_BITS;

    // Configuration
    logic [MIRROR_COUNT_W-1:0] mirror_count_reg;
    logic [PRESENT_MASK_W-1:0] present_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_count_reg <= MIRROR_COUNT_RST;
            present_mask_reg <= PRESENT_MASK_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIRROR_COUNT: mirror_count_reg <= cfg_wdata[MIRROR_COUNT_W-1:0];
                REG_PRESENT_MASK: present_mask_reg <= cfg_wdata[PRESENT_MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Held item
    logic                     item_pick_reg;
    logic [MIRROR_IDX_W-1:0]  item_idx_reg;
    logic [BLOCK_COUNT_W-1:0] item_blocks_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_pick_reg   <= (s_cmd == CMD_PICK);
            item_idx_reg    <= s_mirror_index;
            item_blocks_reg <= s_block_count;
        end
    end

    // Outstanding-block counters
    logic [CB-1:0] cnt_reg [MAX_MIRRORS];
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [CB-1:0] wr_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_MIRRORS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (wr_en) begin
            cnt_reg[wr_idx] <= wr_val;
        end
    end

    // Min search, one counter per cycle
    logic [IW-1:0] scan_idx_reg;
    logic [XW-1:0] scan_ext;
    logic          found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [CB-1:0] best_val_reg;
    logic          scan_hit;
    logic [CB-1:0] scan_val;

    assign scan_ext = XW'(scan_idx_reg);
    assign scan_val = cnt_reg[scan_idx_reg];
    assign scan_hit = (CW'(scan_idx_reg) < CW'(mirror_count_reg))
                   && (32'(scan_idx_reg) < 32'(PRESENT_MASK_W))
                   && present_mask_reg[scan_ext[MIRROR_IDX_W-1:0]]
                   && (!found_reg || (scan_val < best_val_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.load) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.scan) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (scan_hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan && scan_hit) begin
            best_idx_reg <= scan_idx_reg;
            best_val_reg <= scan_val;
        end
    end

    // Commit: add or subtract, check range
    logic [XW-1:0] rel_ext;
    logic          rel_ok;
    logic [IW-1:0] tgt_idx;
    logic [CB-1:0] cur_val;
    logic [CB:0]   sum;
    logic [CB:0]   diff;

    logic [MIRROR_IDX_W-1:0] chosen_next;
    logic                    none_next;
    logic                    err_next;
    logic [CB-1:0]           after_next;

    assign rel_ext = XW'(item_idx_reg);
    assign rel_ok  = (32'(rel_ext) < 32'(MAX_MIRRORS));
    assign tgt_idx = item_pick_reg ? best_idx_reg : rel_ext[IW-1:0];
    assign cur_val = item_pick_reg ? best_val_reg : cnt_reg[tgt_idx];
    assign sum     = {1'b0, cur_val} + (CB+1)'(item_blocks_reg);
    assign diff    = {1'b0, cur_val} - (CB+1)'(item_blocks_reg);

    always_comb begin
        chosen_next = '0;
        none_next   = 1'b0;
        err_next    = 1'b0;
        after_next  = '0;
        wr_en       = 1'b0;
        wr_idx      = tgt_idx;
        wr_val      = '0;
        if (item_pick_reg) begin
            if (!found_reg) begin
                none_next = 1'b1;
            end else begin
                chosen_next = MIRROR_IDX_W'(best_idx_reg);
                err_next    = sum[CB];
                after_next  = sum[CB] ? cur_val : sum[CB-1:0];
                wr_en       = cmd.commit && !sum[CB];
                wr_val      = sum[CB-1:0];
            end
        end else if (rel_ok) begin
            err_next   = diff[CB];
            after_next = diff[CB] ? cur_val : diff[CB-1:0];
            wr_en      = cmd.commit && !diff[CB];
            wr_val     = diff[CB-1:0];
        end
    end

    // Result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_chosen_mirror     <= chosen_next;
            m_none_available    <= none_next;
            m_count_error       <= err_next;
            m_outstanding_after <= AFTER_W'(after_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign status.in_pick   = (s_cmd == CMD_PICK);
    assign status.scan_last = (scan_idx_reg == IW'(MAX_MIRRORS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

[hdl/mirror_read_least_outstanding_select.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mirror_read_least_outstanding_select
// Read load balancer that steers each read to the least loaded mirror.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one command per transfer. A pick (s_cmd = 0) chooses the
//   present mirror with the fewest outstanding blocks (lowest index on a
//   tie) and charges s_block_count to it. A release (s_cmd = 1) subtracts
//   s_block_count from mirror s_mirror_index.
//   m_* channel: one result transfer per command, in order.
//   cfg_*: write mirror_count (index 0) and present_mask (index 1) while idle.
// Timing:
//   A pick walks the counters one per cycle and then commits; a release goes
//   straight from load to commit. The result is registered and shows on
//   m_* in the cycle after the commit cycle.
// Reset:
//   aresetn clears all counters, sets mirror_count to 2 and present_mask to
//   all ones, and empties the result register.
// Back-pressure:
//   The next command is taken and searched while a result waits; its commit
//   holds until the receiver takes the earlier result.
// ---------------------------------------------------------------------------
module mirror_read_least_outstanding_select
    import mrlos_pkg::*;
#(
    parameter int MAX_MIRRORS  = MAX_MIRRORS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    // command channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [MIRROR_IDX_W-1:0]  s_mirror_index,
    input  logic [BLOCK_COUNT_W-1:0] s_block_count,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [MIRROR_IDX_W-1:0]  m_chosen_mirror,
    output logic                     m_none_available,
    output logic                     m_count_error,
    output logic [AFTER_W-1:0]       m_outstanding_after
);

    mrlos_cmd_t    ctl_cmd;
    mrlos_status_t dp_status;

    // Sequence load, scan and commit
    mrlos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctl_cmd)
    );

    // Hold counters and do the arithmetic
    mrlos_dp #(
        .MAX_MIRRORS  (MAX_MIRRORS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_cmd               (s_cmd),
        .s_mirror_index      (s_mirror_index),
        .s_block_count       (s_block_count),
        .cmd                 (ctl_cmd),
        .status              (dp_status),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_chosen_mirror     (m_chosen_mirror),
        .m_none_available    (m_none_available),
        .m_count_error       (m_count_error),
        .m_outstanding_after (m_outstanding_after)
    );

    // A "no mirror" result carries no other information
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_none_available) |->
            (!m_count_error && m_chosen_mirror == '0 && m_outstanding_after == '0))
        else $error("none_available result with nonzero fields");

    // Every accepted command keeps the block busy in the cycle after it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted back to back");

    // A new result comes only from a commit, never while taking commands
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a commit cycle");

    // A pick scans the counters before it can complete
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_PICK) |=> ##1 !s_ready)
        else $error("pick finished without scanning");

endmodule
